// ----- rtl/ths_pkg.sv -----
package ths_pkg;

  // Fixed widths of the key, the message bytes and the hash result
  localparam int KEY_WORDS = 4;
  localparam int WORD_W    = 64;
  localparam int KEY_W     = KEY_WORDS * WORD_W;
  localparam int KEY_EXT_W = KEY_W + WORD_W;   // room for windows that run past the key
  localparam int HASH_W    = 32;
  localparam int DATA_W    = 8;
  localparam int CNT_W     = 4;
  localparam int POS_W     = 8;                // holds any message length up to 255
  localparam int CFG_IDX_W = 2;

  // Default sizes
  localparam int HASH_BITS_DEF    = 32;
  localparam int MAX_MSG_BITS_DEF = 192;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_3 = 2'd3;

  // One item as it travels down the row of cells
  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [CNT_W-1:0]  cnt;    // valid bits, already clipped to DATA_W
    logic [POS_W-1:0]  pos;    // message position of data bit 0
    logic              last;
    logic              ovf;    // bits of this message were dropped so far
    logic [HASH_W-1:0] part;   // xor of windows picked up so far
  } ths_item_t;

endpackage

// ----- rtl/toeplitz_hash_stream.sv -----
// Streaming Toeplitz hash over GF(2). Message bytes enter one per cycle, bit 0
// first, with bit_count giving the valid low bits (0 takes no bits, above 8
// counts as 8); the item marked last returns the 32-bit hash and an overflow
// flag, then the message state clears. Each byte passes a row of eight cells,
// one per data bit, each xoring the key window at its bit's position into the
// item's partial sum; a final stage folds partial sums into the running hash.
// Throughput is one item per cycle unless stalled; a result passes the eight
// cell registers, then the result register. The key is four 64-bit registers;
// the user must write them through cfg_* only while no message is in flight
// (unenforced). Bits past MAX_MSG_BITS are dropped and reported in out_overflow.
module toeplitz_hash_stream import ths_pkg::*; #(
  parameter int HASH_BITS    = HASH_BITS_DEF,
  parameter int MAX_MSG_BITS = MAX_MSG_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [WORD_W-1:0]    cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [DATA_W-1:0]    in_data_byte,
  input  logic [CNT_W-1:0]     in_bit_count,
  input  logic                 in_last,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [HASH_W-1:0]    out_hash_value,
  output logic                 out_overflow
);

  logic [WORD_W-1:0] key_r [KEY_WORDS];
  logic [KEY_W-1:0]  key;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic              ovf_r, ovf_nxt;
  logic [CNT_W-1:0]  cnt_c;
  logic [POS_W:0]    end_pos;
  logic              item_ovf;
  logic              accept;
  ths_item_t         head_item;

  logic              c_valid [DATA_W+1];
  logic              c_ready [DATA_W+1];
  ths_item_t         c_item  [DATA_W+1];

  // Key registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int w = 0; w < KEY_WORDS; w++) key_r[w] <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_KEY_WORD_0: key_r[0] <= cfg_wdata;
        REG_KEY_WORD_1: key_r[1] <= cfg_wdata;
        REG_KEY_WORD_2: key_r[2] <= cfg_wdata;
        REG_KEY_WORD_3: key_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign key = {key_r[3], key_r[2], key_r[1], key_r[0]};

  // Message position and overflow tracking at the input
  assign accept   = in_valid && in_ready;
  assign cnt_c    = (in_bit_count > CNT_W'(DATA_W)) ? CNT_W'(DATA_W) : in_bit_count;
  assign end_pos  = {1'b0, pos_r} + (POS_W+1)'(cnt_c);
  assign item_ovf = ovf_r || (end_pos > (POS_W+1)'(MAX_MSG_BITS));

  always_comb begin
    pos_nxt = pos_r;
    ovf_nxt = ovf_r;
    if (accept) begin
      if (in_last) begin
        pos_nxt = '0;
        ovf_nxt = 1'b0;
      end else begin
        pos_nxt = (end_pos > (POS_W+1)'(MAX_MSG_BITS)) ? POS_W'(MAX_MSG_BITS)
                                                       : end_pos[POS_W-1:0];
        ovf_nxt = item_ovf;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      ovf_r <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  always_comb begin
    head_item.data = in_data_byte;
    head_item.cnt  = cnt_c;
    head_item.pos  = pos_r;
    head_item.last = in_last;
    head_item.ovf  = item_ovf;
    head_item.part = '0;
  end

  assign c_valid[0] = in_valid;
  assign c_item[0]  = head_item;
  assign in_ready   = c_ready[0];

  // One cell per data bit
  for (genvar k = 0; k < DATA_W; k++) begin : g_cell
    ths_cell #(
      .IDX          (k),
      .HASH_BITS    (HASH_BITS),
      .MAX_MSG_BITS (MAX_MSG_BITS)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .key       (key),
      .in_valid  (c_valid[k]),
      .in_item   (c_item[k]),
      .in_ready  (c_ready[k]),
      .out_valid (c_valid[k+1]),
      .out_item  (c_item[k+1]),
      .out_ready (c_ready[k+1])
    );
  end

  // Running hash and result register
  ths_acc u_acc (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (c_valid[DATA_W]),
    .in_item        (c_item[DATA_W]),
    .in_ready       (c_ready[DATA_W]),
    .out_valid      (out_valid),
    .out_hash_value (out_hash_value),
    .out_overflow   (out_overflow),
    .out_ready      (out_ready)
  );

endmodule

// ----- rtl/ths_cell.sv -----
module ths_cell import ths_pkg::*; #(
  parameter int IDX          = 0,
  parameter int HASH_BITS    = HASH_BITS_DEF,
  parameter int MAX_MSG_BITS = MAX_MSG_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [KEY_W-1:0] key,
  input  logic             in_valid,
  input  ths_item_t        in_item,
  output logic             in_ready,
  output logic             out_valid,
  output ths_item_t        out_item,
  input  logic             out_ready
);

  localparam int KEPT = (HASH_BITS < HASH_W) ? HASH_BITS : HASH_W;

  logic              valid_r, valid_nxt;
  ths_item_t         item_r, item_nxt;
  logic [POS_W:0]    bit_pos;
  logic              take;
  logic [KEY_EXT_W-1:0] key_sh;
  logic [HASH_W-1:0] window;

  // Message position of the bit this cell handles
  assign bit_pos = {1'b0, in_item.pos} + (POS_W+1)'(IDX);
  assign take    = (CNT_W'(IDX) < in_item.cnt) &&
                   (bit_pos < (POS_W+1)'(MAX_MSG_BITS)) &&
                   in_item.data[IDX];

  // Key window starting at this position; key bits past the key read as 0
  assign key_sh = {{WORD_W{1'b0}}, key} >> bit_pos;

  for (genvar i = 0; i < HASH_W; i++) begin : g_win
    if (i < KEPT) begin : g_kept
      assign window[i] = key_sh[HASH_BITS-1-i];
    end else begin : g_drop
      assign window[i] = 1'b0;
    end
  end

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    item_nxt      = in_item;
    item_nxt.part = in_item.part ^ (take ? window : '0);
    valid_nxt     = in_ready ? in_valid : valid_r;
  end

  // Stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= item_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule

// ----- rtl/ths_acc.sv -----
module ths_acc import ths_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  ths_item_t         in_item,
  output logic              in_ready,
  output logic              out_valid,
  output logic [HASH_W-1:0] out_hash_value,
  output logic              out_overflow,
  input  logic              out_ready
);

  logic [HASH_W-1:0] acc_r, acc_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [HASH_W-1:0] hash_r;
  logic              ovf_r;
  logic              take;
  logic              slot_free;

  // A non-last item always folds into the accumulator; a last one needs the slot
  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = !in_item.last || slot_free;
  assign take      = in_valid && in_ready;

  always_comb begin
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (take) begin
      if (in_item.last) begin
        acc_nxt       = '0;
        out_valid_nxt = 1'b1;
      end else begin
        acc_nxt = acc_r ^ in_item.part;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (take && in_item.last) begin
      hash_r <= acc_r ^ in_item.part;
      ovf_r  <= in_item.ovf;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hash_value = hash_r;
  assign out_overflow   = ovf_r;

endmodule

// ----- rtl/ths_check.sv -----
module ths_check import ths_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              in_last,
  input logic              out_valid,
  input logic              out_ready,
  input logic [HASH_W-1:0] out_hash_value,
  input logic              out_overflow
);

  // Results in flight: eight cells and the result register
  localparam int DEPTH  = DATA_W + 1;
  localparam int PEND_W = $clog2(DEPTH + 2);

  logic [PEND_W-1:0] pend_r;
  logic              inc, dec;

  assign inc = in_valid && in_ready && in_last;
  assign dec = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + PEND_W'(inc) - PEND_W'(dec);
    end
  end

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hash_value) &&
                                $stable(out_overflow))
    else $error("result changed while stalled");

  // Every result belongs to an accepted last item
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != '0)
    else $error("result without a finished message");

  // The row never holds more messages than it has stages
  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= PEND_W'(DEPTH))
    else $error("too many messages in flight");

  // With the output draining, input is never held off
  a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output ready");

endmodule

bind toeplitz_hash_stream ths_check u_check (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .in_last        (in_last),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_hash_value (out_hash_value),
  .out_overflow   (out_overflow)
);

// ----- bench/tb_toeplitz_hash_stream.sv -----
`timescale 1ns / 100ps

module tb_toeplitz_hash_stream;
  import ths_pkg::*;

  localparam int HASH_BITS     = HASH_BITS_DEF;
  localparam int MAX_MSG_BITS  = MAX_MSG_BITS_DEF;
  localparam int KEPT_BITS     = (HASH_BITS < HASH_W) ? HASH_BITS : HASH_W;
  localparam int FULL_BYTES    = MAX_MSG_BITS / DATA_W;  // bytes that fill a message exactly
  localparam int IDLE_PCT      = 21;
  localparam int SETTLE_CYCLES = 20;
  localparam int MAX_REPORTS   = 30;
  localparam int ITEMS_PER_KEY = 300;

  typedef struct packed {
    logic [HASH_W-1:0] hash_value;
    logic              overflow;
  } hash_result_t;

  logic                 clk          = 1'b0;
  logic                 rst_n        = 1'b0;
  logic                 cfg_wr_en    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr     = '0;
  logic [WORD_W-1:0]    cfg_wdata    = '0;
  logic                 in_valid     = 1'b0;
  logic                 in_ready;
  logic [DATA_W-1:0]    in_data_byte = '0;
  logic [CNT_W-1:0]     in_bit_count = '0;
  logic                 in_last      = 1'b0;
  logic                 out_valid;
  logic                 out_ready    = 1'b0;
  logic [HASH_W-1:0]    out_hash_value;
  logic                 out_overflow;

  // Predictor state: key, running hash, message position, dropped-bit flag
  logic [KEY_W-1:0]  key_bits   = '0;
  logic [HASH_W-1:0] hash_acc   = '0;
  int unsigned       msg_pos    = 0;
  logic              bits_lost  = 1'b0;
  hash_result_t      hash_q[$];

  bit          gaps_on = 1'b1;
  int unsigned err_count = 0;
  int unsigned items_sent = 0;
  int unsigned hashes_checked = 0;
  int unsigned overflow_hashes = 0;
  int unsigned key_settings = 0;

  toeplitz_hash_stream i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data_byte   (in_data_byte),
    .in_bit_count   (in_bit_count),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hash_value (out_hash_value),
    .out_overflow   (out_overflow)
  );

  // Clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Hash prediction
  function automatic logic key_at(int unsigned idx);
    if (idx >= KEY_W) return 1'b0;  // windows past the key read zero
    return key_bits[idx];
  endfunction

  function automatic void absorb_bit(logic b);
    if (msg_pos >= MAX_MSG_BITS) begin
      bits_lost = 1'b1;
      return;
    end
    if (b) begin
      for (int i = 0; i < KEPT_BITS; i++)
        hash_acc[i] = hash_acc[i] ^ key_at(msg_pos + HASH_BITS - 1 - i);
    end
    msg_pos++;
  endfunction

  function automatic void absorb_item(input logic [DATA_W-1:0] data,
                                      input logic [CNT_W-1:0] cnt,
                                      input logic fin);
    int unsigned  n;
    hash_result_t res;
    n = (cnt > DATA_W) ? DATA_W : cnt;
    for (int k = 0; k < n; k++)
      absorb_bit(data[k]);
    if (fin) begin
      res.hash_value = hash_acc;
      res.overflow   = bits_lost;
      hash_q.push_back(res);
      hash_acc  = '0;
      msg_pos   = 0;
      bits_lost = 1'b0;
    end
  endfunction

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= MAX_REPORTS)
      $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  // Result side: random backpressure
  always @(posedge clk) begin
    if (gaps_on)
      out_ready <= ($urandom_range(99) >= IDLE_PCT);
    else
      out_ready <= 1'b1;
  end

  // Result checker
  always @(posedge clk) begin
    hash_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (hash_q.size() == 0) begin
        report_mismatch($sformatf("hash %h with no message pending", out_hash_value));
      end else begin
        want = hash_q.pop_front();
        hashes_checked++;
        if (want.overflow) overflow_hashes++;
        if (out_hash_value !== want.hash_value)
          report_mismatch($sformatf("hash %h, expected %h", out_hash_value,
                                    want.hash_value));
        if (out_overflow !== want.overflow)
          report_mismatch($sformatf("overflow %b, expected %b", out_overflow,
                                    want.overflow));
      end
    end
  end

  // One input item, with optional idle cycles in front
  task automatic send_byte(input logic [DATA_W-1:0] data, input logic [CNT_W-1:0] cnt,
                           input logic fin);
    while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= data;
    in_bit_count <= cnt;
    in_last      <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    absorb_item(data, cnt, fin);
    items_sent++;
  endtask

  // Random message; full_pct sets how often a byte carries all eight bits
  task automatic send_message(input int unsigned len, input int unsigned full_pct);
    logic [DATA_W-1:0] data;
    logic [CNT_W-1:0]  cnt;
    for (int n = 1; n <= len; n++) begin
      data = DATA_W'($urandom());
      if ($urandom_range(99) < full_pct)
        cnt = CNT_W'(DATA_W);
      else
        cnt = CNT_W'($urandom_range(15, 0));
      send_byte(data, cnt, n == len);
    end
  endtask

  // Let all hashes come back and the pipeline empty out
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (hash_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all four key words back to back
  task automatic load_key(input logic [KEY_W-1:0] key);
    for (int w = 0; w < KEY_WORDS; w++) begin
      cfg_wr_en <= 1'b1;
      case (w)
        0: cfg_addr <= REG_KEY_WORD_0;
        1: cfg_addr <= REG_KEY_WORD_1;
        2: cfg_addr <= REG_KEY_WORD_2;
        default: cfg_addr <= REG_KEY_WORD_3;
      endcase
      cfg_wdata <= key[w*WORD_W +: WORD_W];
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
    key_bits = key;
    key_settings++;
  endtask

  function automatic logic [KEY_W-1:0] random_key();
    logic [KEY_W-1:0] key;
    for (int w = 0; w < KEY_W / 32; w++)
      key[w*32 +: 32] = $urandom();
    return key;
  endfunction

  // Key still at reset: every hash is zero
  task automatic test_reset_key();
    send_byte(8'hFF, 4'd8, 1'b0);
    send_byte(8'hFF, 4'd8, 1'b1);
    send_message(4, 75);
  endtask

  // Empty messages, zero and oversized bit counts, partial final byte
  task automatic test_bit_counts();
    wait_idle();
    load_key(random_key());
    send_byte(8'hFF, 4'd0, 1'b1);
    send_byte(8'hA5, 4'd0, 1'b0);
    send_byte(8'hFF, 4'd8, 1'b1);
    send_byte(8'h3C, 4'd15, 1'b0);
    send_byte(8'hC3, 4'd9, 1'b1);
    send_byte(8'hFF, 4'd8, 1'b0);
    send_byte(8'h01, 4'd1, 1'b1);
    send_byte(8'h00, 4'd8, 1'b1);
    send_byte(8'h80, 4'd8, 1'b1);
    send_byte(8'h7F, 4'd7, 1'b1);
  endtask

  // Messages at and past the maximum length
  task automatic test_length_limit();
    wait_idle();
    load_key(random_key());
    // exactly full, then one bit over
    for (int n = 1; n <= FULL_BYTES; n++) send_byte(8'hFF, 4'd8, n == FULL_BYTES);
    for (int n = 1; n <= FULL_BYTES; n++) send_byte(DATA_W'($urandom()), 4'd8, 1'b0);
    send_byte(8'h01, 4'd1, 1'b1);
    // short message right after an overflow must come back clean
    send_message(2, 100);
    for (int m = 0; m < 10; m++)
      send_message($urandom_range(FULL_BYTES + 6, FULL_BYTES - 4), 85);
  endtask

  // Mostly short messages, some long ones, under a given key
  task automatic test_random_messages(input logic [KEY_W-1:0] key, input int unsigned n_items);
    int unsigned start;
    wait_idle();
    load_key(key);
    start = items_sent;
    while (items_sent - start < n_items) begin
      if ($urandom_range(99) < 90)
        send_message($urandom_range(8, 1), 75);
      else
        send_message($urandom_range(FULL_BYTES + 6, FULL_BYTES - 4), 85);
    end
  endtask

  // Sequence
  initial begin
    logic [KEY_W-1:0] one_hot;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_key();
    test_bit_counts();
    test_length_limit();
    test_random_messages('1, ITEMS_PER_KEY);
    test_random_messages(random_key(), ITEMS_PER_KEY);
    gaps_on = 1'b0;
    test_random_messages(random_key(), ITEMS_PER_KEY);
    gaps_on = 1'b1;
    one_hot = '0;
    one_hot[$urandom_range(KEY_W - 1, 0)] = 1'b1;
    test_random_messages(one_hot, ITEMS_PER_KEY / 2);
    test_random_messages({(KEY_W / 2){2'b01}}, ITEMS_PER_KEY / 2);
    test_random_messages(random_key(), ITEMS_PER_KEY);
    test_random_messages('0, 40);
    wait_idle();

    $display("Sent %0d items under %0d key settings, zero/all-ones/one-hot/random keys.",
             items_sent, key_settings);
    $display("Checked %0d hashes, %0d of them for over-length messages; %0d mismatches.",
             hashes_checked, overflow_hashes, err_count);
    if (err_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- toeplitz_hash_stream.f -----
rtl/ths_pkg.sv
rtl/ths_cell.sv
rtl/ths_acc.sv
rtl/toeplitz_hash_stream.sv
rtl/ths_check.sv
bench/tb_toeplitz_hash_stream.sv
